FILE: rtl/atc_pkg.sv
// ----------------------------------------------------------------------------
// atc_pkg
// Shared types, codes and helper functions of the assembler token classifier.
// ----------------------------------------------------------------------------
package atc_pkg;

  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_CHAR = 2'd1;
  localparam logic [1:0] FUNC_EOL  = 2'd2;

  localparam logic [2:0] QUOTE_TABLE   = 3'd4;
  localparam logic [6:0] QUOTE_INDEX   = 7'd13;
  localparam logic [2:0] HASH_TABLE0   = 3'd5;
  localparam logic [7:0] CASE_SHIFT    = 8'd32;
  localparam logic [3:0] ENTRY_MAX_LEN = 4'd8;
  localparam logic [1:0] LAST_PRESET   = 2'd3;
  localparam logic [1:0] LAST_HASH     = 2'd2;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_QUOTE = 8'h27;

  typedef enum logic [2:0] {
    ACT_NOP,
    ACT_ADD,
    ACT_SKIP,
    ACT_CLASS,
    ACT_CLASS_ADD
  } act_t;

  typedef struct packed {
    logic capture;
    logic res_load;
    logic char_add;
    logic char_skip;
    logic res_quote;
    logic p_init;
    logic p_next_tbl;
    logic p_step;
    logic res_preset;
    logic h_init;
    logic h_step;
    logic h_next_tbl;
    logic res_hash;
    logic m_init;
    logic m_sub;
    logic q_init;
    logic q_step;
    logic q_write;
    logic res_full;
    logic push_tok;
    logic push_eol;
    logic push_last;
    logic clr_step;
    logic clr_skip;
  } cmd_t;

  typedef struct packed {
    logic [1:0] func;
    logic       sel_ok;
    act_t       act;
    logic       tok_nonempty;
    logic       quote;
    logic       p_end;
    logic       p_last_tbl;
    logic       p_match;
    logic       h_match;
    logic       h_last_slot;
    logic       h_last_tbl;
    logic       m_ge;
    logic       q_empty;
    logic       q_last;
    logic       out_free;
    logic       clr_done;
  } sts_t;

  function automatic logic is_letter(input logic [7:0] c);
    return (c inside {[8'h61:8'h7a], [8'h41:8'h5a]});
  endfunction

  function automatic logic is_digit_kind(input logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h48]});
  endfunction

  function automatic logic [63:0] len_mask(input logic [3:0] len);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < len) m[8*i +: 8] = 8'hff;
    end
    return m;
  endfunction

  function automatic logic [63:0] case_shift(input logic [63:0] t, input logic [3:0] len);
    logic [63:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < len) r[8*i +: 8] = t[8*i +: 8] + CASE_SHIFT;
    end
    return r;
  endfunction

endpackage

FILE: rtl/atc_ctrl.sv
// ----------------------------------------------------------------------------
// atc_ctrl
// Sequencer: decodes items, steps the table searches and probing, emits results.
// ----------------------------------------------------------------------------
module atc_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  atc_pkg::sts_t sts,
  output atc_pkg::cmd_t cmd
);
  import atc_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_CLS, S_P_CHECK, S_P_CMP, S_H_READ, S_H_CMP,
    S_MOD, S_Q_READ, S_Q_CMP, S_EMIT_TOK, S_EMIT_EOL
  } state_t;

  state_t state, state_next;
  logic   add_after, add_after_next;

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd            = '0;
    state_next     = state;
    add_after_next = add_after;
    cmd.push_last  = (sts.func != FUNC_EOL);
    case (state)
      S_CLEAR: begin
        if (sts.clr_done) state_next = S_IDLE;
        else cmd.clr_step = 1'b1;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (sts.func)
          FUNC_LOAD: begin
            add_after_next = 1'b0;
            if (sts.sel_ok) begin
              cmd.res_load = 1'b1;
              state_next   = S_EMIT_TOK;
            end else begin
              state_next = S_IDLE;
            end
          end
          FUNC_CHAR: begin
            add_after_next = (sts.act == ACT_CLASS_ADD);
            case (sts.act)
              ACT_ADD: begin
                cmd.char_add = 1'b1;
                state_next   = S_IDLE;
              end
              ACT_SKIP: begin
                cmd.char_skip = 1'b1;
                state_next    = S_IDLE;
              end
              ACT_CLASS, ACT_CLASS_ADD: state_next = S_CLS;
              default: state_next = S_IDLE;
            endcase
          end
          FUNC_EOL: begin
            add_after_next = 1'b0;
            state_next     = sts.tok_nonempty ? S_CLS : S_EMIT_EOL;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_CLS: begin
        if (sts.quote) begin
          cmd.res_quote = 1'b1;
          state_next    = S_EMIT_TOK;
        end else begin
          cmd.p_init = 1'b1;
          state_next = S_P_CHECK;
        end
      end
      S_P_CHECK: begin
        if (sts.p_end) begin
          if (sts.p_last_tbl) begin
            cmd.h_init = 1'b1;
            state_next = S_H_READ;
          end else begin
            cmd.p_next_tbl = 1'b1;
          end
        end else begin
          state_next = S_P_CMP;
        end
      end
      S_P_CMP: begin
        if (sts.p_match) begin
          cmd.res_preset = 1'b1;
          state_next     = S_EMIT_TOK;
        end else begin
          cmd.p_step = 1'b1;
          state_next = S_P_CHECK;
        end
      end
      S_H_READ: state_next = S_H_CMP;
      S_H_CMP: begin
        if (sts.h_match) begin
          cmd.res_hash = 1'b1;
          state_next   = S_EMIT_TOK;
        end else if (sts.h_last_slot) begin
          if (sts.h_last_tbl) begin
            cmd.m_init = 1'b1;
            state_next = S_MOD;
          end else begin
            cmd.h_next_tbl = 1'b1;
            state_next     = S_H_READ;
          end
        end else begin
          cmd.h_step = 1'b1;
          state_next = S_H_READ;
        end
      end
      S_MOD: begin
        if (sts.m_ge) begin
          cmd.m_sub = 1'b1;
        end else begin
          cmd.q_init = 1'b1;
          state_next = S_Q_READ;
        end
      end
      S_Q_READ: state_next = S_Q_CMP;
      S_Q_CMP: begin
        if (sts.q_empty) begin
          cmd.q_write  = 1'b1;
          cmd.res_hash = 1'b1;
          state_next   = S_EMIT_TOK;
        end else if (sts.q_last) begin
          cmd.res_full = 1'b1;
          state_next   = S_EMIT_TOK;
        end else begin
          cmd.q_step = 1'b1;
          state_next = S_Q_READ;
        end
      end
      S_EMIT_TOK: begin
        if (sts.out_free) begin
          cmd.push_tok = 1'b1;
          if (sts.func == FUNC_EOL) begin
            state_next = S_EMIT_EOL;
          end else begin
            cmd.char_add = add_after;
            state_next   = S_IDLE;
          end
        end
      end
      S_EMIT_EOL: begin
        if (sts.out_free) begin
          cmd.push_eol = 1'b1;
          cmd.clr_skip = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      add_after <= 1'b0;
    end else begin
      state     <= state_next;
      add_after <= add_after_next;
    end
  end

endmodule

FILE: rtl/atc_dp.sv
// ----------------------------------------------------------------------------
// atc_dp
// Datapath: token assembly, preset and hash memories, counters, output register.
// ----------------------------------------------------------------------------
module atc_dp #(
  parameter int PRESET_DEPTH = 128,
  parameter int HASH_SLOTS   = 100,
  parameter int TOKEN_CHARS  = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  atc_pkg::cmd_t cmd,
  output atc_pkg::sts_t sts,
  input  logic [1:0]    func,
  input  logic [2:0]    table_select,
  input  logic [63:0]   entry_text,
  input  logic [3:0]    entry_length,
  input  logic [7:0]    source_char,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [2:0]    table_number,
  output logic [6:0]    entry_index,
  output logic          line_end,
  output logic          truncated,
  output logic          table_full,
  output logic          last
);
  import atc_pkg::*;

  localparam int PW   = $clog2(PRESET_DEPTH);
  localparam int HW   = $clog2(HASH_SLOTS);
  localparam int CLRW = HW + 3;
  localparam logic [3:0]    TOK_MAX  = 4'(TOKEN_CHARS);
  localparam logic [3:0]    CUT_LEN  = 4'(TOKEN_CHARS + 1);
  localparam logic [PW:0]   PDEPTH   = (PW+1)'(PRESET_DEPTH);
  localparam logic [10:0]   SLOTS    = 11'(HASH_SLOTS);
  localparam logic [HW-1:0] SLOT_TOP = HW'(HASH_SLOTS - 1);

  logic [1:0]  c_func;
  logic [2:0]  c_sel;
  logic [63:0] c_text;
  logic [3:0]  c_len;
  logic [7:0]  c_char;

  logic [63:0] tok_text;
  logic [3:0]  tok_len;
  logic [10:0] tok_sum;
  logic        in_string;
  logic        skip;

  logic [67:0]   pmem [0:(4<<PW)-1];
  logic [67:0]   pr_q;
  logic [PW-1:0] pcount [4];
  logic [1:0]    p_t;
  logic [PW:0]   p_i;

  logic [67:0]     hmem [0:(4<<HW)-1];
  logic [67:0]     hr_q;
  logic [1:0]      h_t;
  logic [HW-1:0]   h_i;
  logic [HW-1:0]   pc;
  logic [10:0]     msum;
  logic [CLRW-1:0] clr_addr;

  logic [2:0] res_table;
  logic [6:0] res_index;
  logic       res_cut;
  logic       res_full;

  logic [3:0]    eff;
  logic          cut;
  logic [7:0]    first;
  logic [1:0]    sel_m1;
  logic [1:0]    cnt_t;
  logic [PW-1:0] cnt_cur;
  logic [PW:0]   cnt_inc;
  logic          load_ok;
  logic [3:0]    load_len;
  logic [1:0]    class_tbl;
  logic [HW+1:0] hwaddr;
  act_t          act;

  assign eff       = (tok_len > TOK_MAX) ? TOK_MAX : tok_len;
  assign cut       = (tok_len > TOK_MAX);
  assign first     = tok_text[7:0];
  assign sel_m1    = 2'(c_sel - 3'd1);
  assign cnt_t     = (c_func == FUNC_LOAD) ? sel_m1 : p_t;
  assign cnt_cur   = pcount[cnt_t];
  assign cnt_inc   = {1'b0, cnt_cur} + (PW+1)'(1);
  assign load_ok   = (cnt_inc < PDEPTH);
  assign load_len  = (c_len > ENTRY_MAX_LEN) ? ENTRY_MAX_LEN : c_len;
  assign class_tbl = in_string ? 2'd2 : (is_digit_kind(first) ? 2'd1 : 2'd0);
  assign hwaddr    = cmd.clr_step ? clr_addr[HW+1:0] : {h_t, h_i};

  always_comb begin
    if (skip) begin
      act = ACT_NOP;
    end else if (tok_len == 4'd0) begin
      act = (c_char != CH_SPACE) ? ACT_ADD : ACT_NOP;
    end else if (tok_len == 4'd1 && first == CH_SEMI && !in_string) begin
      act = ACT_SKIP;
    end else if ((is_letter(first) && is_letter(c_char)) ||
                 (is_digit_kind(first) && is_digit_kind(c_char))) begin
      act = ACT_ADD;
    end else if (c_char == CH_SPACE) begin
      act = ACT_CLASS;
    end else begin
      act = ACT_CLASS_ADD;
    end
  end

  always_comb begin
    sts              = '0;
    sts.func         = c_func;
    sts.sel_ok       = (c_sel >= 3'd1) && (c_sel <= 3'd4);
    sts.act          = act;
    sts.tok_nonempty = (tok_len != 4'd0);
    sts.quote        = (eff == 4'd1) && (first == CH_QUOTE);
    sts.p_end        = (p_i > {1'b0, cnt_cur});
    sts.p_last_tbl   = (p_t == LAST_PRESET);
    sts.p_match      = (pr_q[67:64] == eff) &&
                       ((pr_q[63:0] == tok_text) ||
                        (p_t != LAST_PRESET &&
                         case_shift(pr_q[63:0], pr_q[67:64]) == tok_text));
    sts.h_match      = (hr_q[67:64] == eff) && (hr_q[63:0] == tok_text);
    sts.h_last_slot  = (h_i == SLOT_TOP);
    sts.h_last_tbl   = (h_t == LAST_HASH);
    sts.m_ge         = (msum >= SLOTS);
    sts.q_empty      = (hr_q[67:64] == 4'd0);
    sts.q_last       = (pc == SLOT_TOP);
    sts.out_free     = !out_valid || !out_stall;
    sts.clr_done     = clr_addr[CLRW-1];
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.res_load && load_ok) begin
      pmem[{sel_m1, cnt_inc[PW-1:0]}] <= {load_len, c_text & len_mask(load_len)};
    end
    pr_q <= pmem[{p_t, p_i[PW-1:0]}];
    if (cmd.clr_step || cmd.q_write) begin
      hmem[hwaddr] <= cmd.clr_step ? 68'd0 : {eff, tok_text};
    end
    hr_q <= hmem[{h_t, h_i}];
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      c_func <= func;
      c_sel  <= table_select;
      c_text <= entry_text;
      c_len  <= entry_length;
      c_char <= source_char;
    end
    if (cmd.p_init) begin
      p_t <= 2'd0;
      p_i <= (PW+1)'(1);
    end else if (cmd.p_next_tbl) begin
      p_t <= p_t + 2'd1;
      p_i <= (PW+1)'(1);
    end else if (cmd.p_step) begin
      p_i <= p_i + (PW+1)'(1);
    end
    if (cmd.h_init) begin
      h_t <= 2'd0;
      h_i <= '0;
    end else if (cmd.h_next_tbl) begin
      h_t <= h_t + 2'd1;
      h_i <= '0;
    end else if (cmd.h_step) begin
      h_i <= h_i + HW'(1);
    end else if (cmd.q_init) begin
      h_t <= class_tbl;
      h_i <= msum[HW-1:0];
      pc  <= '0;
    end else if (cmd.q_step) begin
      h_i <= (h_i == SLOT_TOP) ? '0 : h_i + HW'(1);
      pc  <= pc + HW'(1);
    end
    if (cmd.m_init) msum <= tok_sum;
    else if (cmd.m_sub) msum <= msum - SLOTS;
    if (cmd.res_load) begin
      res_table <= c_sel;
      res_index <= load_ok ? 7'(cnt_inc) : 7'd0;
      res_cut   <= 1'b0;
      res_full  <= !load_ok;
    end else if (cmd.res_quote) begin
      res_table <= QUOTE_TABLE;
      res_index <= QUOTE_INDEX;
      res_cut   <= 1'b0;
      res_full  <= 1'b0;
    end else if (cmd.res_preset) begin
      res_table <= {1'b0, p_t} + 3'd1;
      res_index <= 7'(p_i);
      res_cut   <= cut;
      res_full  <= 1'b0;
    end else if (cmd.res_hash) begin
      res_table <= HASH_TABLE0 + {1'b0, h_t};
      res_index <= 7'(h_i);
      res_cut   <= cut;
      res_full  <= 1'b0;
    end else if (cmd.res_full) begin
      res_table <= HASH_TABLE0 + {1'b0, h_t};
      res_index <= 7'd0;
      res_cut   <= cut;
      res_full  <= 1'b1;
    end
    if (cmd.push_tok) begin
      table_number <= res_table;
      entry_index  <= res_index;
      line_end     <= 1'b0;
      truncated    <= res_cut;
      table_full   <= res_full;
      last         <= cmd.push_last;
    end else if (cmd.push_eol) begin
      table_number <= 3'd0;
      entry_index  <= 7'd0;
      line_end     <= 1'b1;
      truncated    <= 1'b0;
      table_full   <= 1'b0;
      last         <= 1'b1;
    end
  end

  // control and token state
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_text  <= '0;
      tok_len   <= '0;
      tok_sum   <= '0;
      in_string <= 1'b0;
      skip      <= 1'b0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < 4; i++) pcount[i] <= '0;
    end else begin
      if (cmd.clr_step) clr_addr <= clr_addr + CLRW'(1);
      if (cmd.res_load && load_ok) pcount[sel_m1] <= cnt_inc[PW-1:0];
      if (cmd.res_quote) in_string <= !in_string;
      if (cmd.res_quote || cmd.res_preset || cmd.res_hash || cmd.res_full) begin
        tok_text <= '0;
        tok_len  <= '0;
        tok_sum  <= '0;
      end else if (cmd.char_add) begin
        if (tok_len < TOK_MAX) begin
          tok_text <= tok_text | ({56'd0, c_char} << {tok_len[2:0], 3'b000});
          tok_len  <= tok_len + 4'd1;
          tok_sum  <= tok_sum + {3'd0, c_char};
        end else begin
          tok_len <= CUT_LEN;
        end
      end
      if (cmd.char_skip) skip <= 1'b1;
      else if (cmd.clr_skip) skip <= 1'b0;
      if (cmd.push_tok || cmd.push_eol) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end

endmodule

FILE: rtl/assembler_token_classifier.sv
// one item at a time: in_stall is high while an item is being worked on
// classifying a token steps through the loaded preset entries and every hash slot until a
// match, then reduces the byte sum mod HASH_SLOTS by subtraction and probes linearly
// the output register holds one result; an item whose result finds it full waits there
// reset: a clearing pass over all 4*2^ceil(log2(HASH_SLOTS)) hash words (512 by default)
// empties the hash tables before the first item is taken
// ----------------------------------------------------------------------------
// assembler_token_classifier
// Splits source characters into tokens and classifies them into preset and
// hash symbol tables with linear probing.
// ----------------------------------------------------------------------------
module assembler_token_classifier #(
  parameter int PRESET_DEPTH = 128,
  parameter int HASH_SLOTS   = 100,
  parameter int TOKEN_CHARS  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [2:0]  table_select,
  input  logic [63:0] entry_text,
  input  logic [3:0]  entry_length,
  input  logic [7:0]  source_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  table_number,
  output logic [6:0]  entry_index,
  output logic        line_end,
  output logic        truncated,
  output logic        table_full,
  output logic        last
);
  import atc_pkg::*;

  cmd_t cmd;
  sts_t sts;

  atc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  atc_dp #(
    .PRESET_DEPTH (PRESET_DEPTH),
    .HASH_SLOTS   (HASH_SLOTS),
    .TOKEN_CHARS  (TOKEN_CHARS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .func         (func),
    .table_select (table_select),
    .entry_text   (entry_text),
    .entry_length (entry_length),
    .source_char  (source_char),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .table_number (table_number),
    .entry_index  (entry_index),
    .line_end     (line_end),
    .truncated    (truncated),
    .table_full   (table_full),
    .last         (last)
  );

endmodule

FILE: rtl/atc_checker.sv
// ----------------------------------------------------------------------------
// atc_checker
// Port-level checks of the assembler token classifier result channel.
// ----------------------------------------------------------------------------
module atc_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_stall,
  input logic [2:0] table_number,
  input logic [6:0] entry_index,
  input logic       line_end,
  input logic       truncated,
  input logic       table_full,
  input logic       last
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(table_number) &&
      $stable(entry_index) && $stable(line_end) && $stable(last))
    else $error("stalled result changed");

  a_eol_form: assert property (@(posedge clk) disable iff (rst)
    out_valid && line_end |-> last && table_number == 3'd0 && !truncated && !table_full)
    else $error("bad end-of-line marker");

  a_token_table: assert property (@(posedge clk) disable iff (rst)
    out_valid && !line_end |-> table_number != 3'd0)
    else $error("token result without table");

  a_full_index: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> entry_index == 7'd0)
    else $error("full table with nonzero index");

endmodule

bind assembler_token_classifier atc_checker u_atc_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .table_number (table_number),
  .entry_index  (entry_index),
  .line_end     (line_end),
  .truncated    (truncated),
  .table_full   (table_full),
  .last         (last)
);
